@@ hdl/pate_pkg.sv @@
// ----------------------------------------------------------------------------
// pate_pkg: shared types and constants
// Kind and status codes, controller states and the command and status
// structs that join the trajectory evaluator's controller and datapath.
// ----------------------------------------------------------------------------
package pate_pkg;

    localparam int DEF_MAX_SEGMENTS = 16;

    localparam logic [1:0] KIND_TRUNC  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LAST,
        ST_SCAN,
        ST_ATP,
        ST_VTP,
        ST_TT,
        ST_ALO,
        ST_AHI,
        ST_ACC,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_ATP,
        MS_VTP,
        MS_TT,
        MS_ALO,
        MS_AHI,
        MS_ACC
    } mul_step_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_FINAL,
        RES_EVAL
    } res_kind_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       clear_prev;
        logic       track;
        logic       capture;
        logic       set_offset;
        logic       append_wr;
        logic       trunc_wr;
        mul_step_t  mul_step;
        logic       res_load;
        res_kind_t  res_kind;
        logic [1:0] res_status;
    } pate_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       rd_valid;
        logic       hit;
        logic       ge_last;
        logic       out_free;
    } pate_stat_t;

endpackage

@@ hdl/pate_if.sv @@
// ----------------------------------------------------------------------------
// pate_if: channel interfaces
// Input item, result item and configuration write channels, each with
// valid/ready and a payload.
// ----------------------------------------------------------------------------
interface pate_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] time_value;
    logic [30:0] seg_end_rel;
    logic [31:0] seg_accel;
    logic [31:0] seg_start_vel;
    logic [31:0] seg_start_pos;

    modport source (output valid, kind, time_value, seg_end_rel, seg_accel,
                    seg_start_vel, seg_start_pos, input ready);
    modport sink (input valid, kind, time_value, seg_end_rel, seg_accel,
                  seg_start_vel, seg_start_pos, output ready);
endinterface

interface pate_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] accel_out;
    logic [31:0] velocity_out;
    logic [31:0] position_out;

    modport source (output valid, status, accel_out, velocity_out, position_out,
                    input ready);
    modport sink (input valid, status, accel_out, velocity_out, position_out,
                  output ready);
endinterface

interface pate_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/pate_datapath.sv @@
// ----------------------------------------------------------------------------
// pate_datapath: segment table and evaluation arithmetic
// Holds the segment memories, count, offset and final position, the end-time
// comparator, a shared 33x33 multiplier with wide accumulators, and the
// result register.
// ----------------------------------------------------------------------------
module pate_datapath #(
    parameter int MAX_SEGMENTS = pate_pkg::DEF_MAX_SEGMENTS,
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pate_pkg::pate_cmd_t     cmd,
    input  logic [AW-1:0]           rd_addr,
    output pate_pkg::pate_stat_t    stat,
    output logic [CW-1:0]           count,
    output logic [AW-1:0]           rd_addr_q,
    input  logic [1:0]              kind,
    input  logic [31:0]             time_value,
    input  logic [30:0]             seg_end_rel,
    input  logic [31:0]             seg_accel,
    input  logic [31:0]             seg_start_vel,
    input  logic [31:0]             seg_start_pos,
    pate_result_if.source           result,
    pate_cfg_if.sink                cfg
);
    logic [31:0] end_mem [0:MAX_SEGMENTS-1];
    logic [31:0] acc_mem [0:MAX_SEGMENTS-1];
    logic [31:0] vel_mem [0:MAX_SEGMENTS-1];
    logic [31:0] pos_mem [0:MAX_SEGMENTS-1];

    logic [1:0]  kind_reg;
    logic [31:0] tv_reg, a_in_reg, v_in_reg, p_in_reg;
    logic [30:0] rel_reg;
    logic [CW-1:0] count_reg;
    logic [31:0] offset_reg, final_pos_reg;
    logic [31:0] end_rd, a_rd, v_rd, p_rd;
    logic        rd_valid_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [31:0] prev_end_reg, tp_reg, a_reg, v_reg, p_reg;
    logic signed [65:0] prod_reg;
    logic [63:0] tp2_reg;
    logic signed [66:0] vel_acc_reg;
    logic signed [99:0] pos_acc_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_acc_reg, out_vel_reg, out_pos_reg;

    logic [31:0] cmp_val;
    logic        hit;
    logic [32:0] app_sum;
    logic [31:0] app_end;
    logic [32:0] tp_diff;
    logic signed [32:0] op_x, op_y;
    logic signed [65:0] prod;
    logic [50:0] vel_sh;
    logic [66:0] pos_sh;
    logic [31:0] vel_sat, pos_sat;
    logic [AW-1:0] app_addr;

    // Queries clamp their time at zero; truncation uses the time as given.
    assign cmp_val = (kind_reg == pate_pkg::KIND_QUERY && tv_reg[31]) ? 32'd0 : tv_reg;
    assign hit     = rd_valid_reg && ($signed(cmp_val) <= $signed(end_rd));

    assign stat.kind     = kind_reg;
    assign stat.rd_valid = rd_valid_reg;
    assign stat.hit      = hit;
    assign stat.ge_last  = $signed(cmp_val) >= $signed(end_rd);
    assign stat.out_free = !out_valid_reg || result.ready;
    assign count         = count_reg;
    assign rd_addr_q     = rd_addr_reg;
    assign cfg.ready     = 1'b1;

    assign app_sum  = {offset_reg[31], offset_reg} + {2'b00, rel_reg};
    assign app_end  = (!app_sum[32] && app_sum[31]) ? 32'h7FFF_FFFF : app_sum[31:0];
    assign app_addr = count_reg[AW-1:0];
    assign tp_diff  = {cmp_val[31], cmp_val} - {prev_end_reg[31], prev_end_reg};

    always_comb
    begin
        unique case (cmd.mul_step)
            pate_pkg::MS_ATP:
            begin
                op_x = {a_reg[31], a_reg};
                op_y = {1'b0, tp_reg};
            end
            pate_pkg::MS_VTP:
            begin
                op_x = {v_reg[31], v_reg};
                op_y = {1'b0, tp_reg};
            end
            pate_pkg::MS_TT:
            begin
                op_x = {1'b0, tp_reg};
                op_y = {1'b0, tp_reg};
            end
            pate_pkg::MS_ALO:
            begin
                op_x = {a_reg[31], a_reg};
                op_y = {1'b0, prod_reg[31:0]};
            end
            pate_pkg::MS_AHI:
            begin
                op_x = {a_reg[31], a_reg};
                op_y = {1'b0, tp2_reg[63:32]};
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign prod = op_x * op_y;

    // Floor division by a power of two is the arithmetic upper slice.
    assign vel_sh  = vel_acc_reg[66:16];
    assign pos_sh  = pos_acc_reg[99:33];
    assign vel_sat = ((&vel_sh[50:31]) || !(|vel_sh[50:31])) ? vel_sh[31:0] :
                     (vel_sh[50] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign pos_sat = ((&pos_sh[66:31]) || !(|pos_sh[66:31])) ? pos_sh[31:0] :
                     (pos_sh[66] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            tv_reg   <= time_value;
            rel_reg  <= seg_end_rel;
            a_in_reg <= seg_accel;
            v_in_reg <= seg_start_vel;
            p_in_reg <= seg_start_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_wr)
        begin
            end_mem[app_addr] <= app_end;
            acc_mem[app_addr] <= a_in_reg;
            vel_mem[app_addr] <= v_in_reg;
            pos_mem[app_addr] <= p_in_reg;
        end
        else if (cmd.trunc_wr)
        begin
            end_mem[rd_addr_reg] <= tv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            end_rd      <= end_mem[rd_addr];
            a_rd        <= acc_mem[rd_addr];
            v_rd        <= vel_mem[rd_addr];
            p_rd        <= pos_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            offset_reg    <= '0;
            final_pos_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cfg.valid)
            begin
                final_pos_reg <= cfg.data;
            end
            if (cmd.set_offset)
            begin
                offset_reg <= tv_reg;
            end
            if (cmd.append_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.trunc_wr)
            begin
                count_reg <= CW'(rd_addr_reg) + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_prev)
        begin
            prev_end_reg <= '0;
        end
        else if (cmd.track && rd_valid_reg && !hit)
        begin
            prev_end_reg <= end_rd;
        end
        if (cmd.capture)
        begin
            a_reg  <= a_rd;
            v_reg  <= v_rd;
            p_reg  <= p_rd;
            tp_reg <= tp_diff[31:0];
        end
        if (cmd.mul_step != pate_pkg::MS_NONE && cmd.mul_step != pate_pkg::MS_ACC)
        begin
            prod_reg <= prod;
        end
        unique case (cmd.mul_step)
            pate_pkg::MS_VTP:
            begin
                vel_acc_reg <= $signed({{19{v_reg[31]}}, v_reg, 16'b0})
                             + $signed({prod_reg[65], prod_reg});
            end
            pate_pkg::MS_TT:
            begin
                pos_acc_reg <= $signed({{35{p_reg[31]}}, p_reg, 33'b0})
                             + $signed({{17{prod_reg[65]}}, prod_reg, 17'b0});
            end
            pate_pkg::MS_ALO:
            begin
                tp2_reg <= prod_reg[63:0];
            end
            pate_pkg::MS_AHI:
            begin
                pos_acc_reg <= pos_acc_reg + $signed({{34{prod_reg[65]}}, prod_reg});
            end
            pate_pkg::MS_ACC:
            begin
                pos_acc_reg <= pos_acc_reg
                             + $signed({{2{prod_reg[65]}}, prod_reg, 32'b0});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            unique case (cmd.res_kind)
                pate_pkg::RES_FINAL:
                begin
                    out_acc_reg <= '0;
                    out_vel_reg <= '0;
                    out_pos_reg <= final_pos_reg;
                end
                pate_pkg::RES_EVAL:
                begin
                    out_acc_reg <= a_reg;
                    out_vel_reg <= vel_sat;
                    out_pos_reg <= pos_sat;
                end
                default:
                begin
                    out_acc_reg <= '0;
                    out_vel_reg <= '0;
                    out_pos_reg <= '0;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.accel_out    = out_acc_reg;
    assign result.velocity_out = out_vel_reg;
    assign result.position_out = out_pos_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count exceeds table depth");
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append_wr |-> count_reg < CW'(MAX_SEGMENTS))
        else $error("append written into a full table");
    a_trunc_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trunc_wr |-> (rd_valid_reg && hit))
        else $error("truncate without a matching segment");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

@@ hdl/pate_ctrl.sv @@
// ----------------------------------------------------------------------------
// pate_ctrl: sequencing controller
// Decodes each item, scans the end-time table one entry per cycle, steps the
// multiplier sequence and loads the result register.
// ----------------------------------------------------------------------------
module pate_ctrl #(
    parameter int MAX_SEGMENTS = pate_pkg::DEF_MAX_SEGMENTS,
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pate_pkg::pate_stat_t    stat,
    input  logic [CW-1:0]           count,
    input  logic [AW-1:0]           rd_addr_q,
    output pate_pkg::pate_cmd_t     cmd,
    output logic [AW-1:0]           rd_addr
);
    pate_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    pate_pkg::res_kind_t res_kind_reg, res_kind_next;
    logic [1:0]          res_status_reg, res_status_next;

    logic [CW-1:0] last_idx;
    logic          scan_last;
    logic          empty;
    logic          full;

    assign last_idx  = count - 1'b1;
    assign scan_last = rd_addr_q == last_idx[AW-1:0];
    assign empty     = count == '0;
    assign full      = count >= CW'(MAX_SEGMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pate_pkg::ST_IDLE;
            idx_reg        <= '0;
            res_kind_reg   <= pate_pkg::RES_PLAIN;
            res_status_reg <= pate_pkg::STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            res_kind_reg   <= res_kind_next;
            res_status_reg <= res_status_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            pate_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pate_pkg::ST_DECODE;
                end
            end
            pate_pkg::ST_DECODE:
            begin
                res_kind_next   = pate_pkg::RES_PLAIN;
                res_status_next = pate_pkg::STAT_OK;
                state_next      = pate_pkg::ST_FINISH;
                unique case (stat.kind)
                    pate_pkg::KIND_TRUNC:
                    begin
                        if (!empty)
                        begin
                            state_next = pate_pkg::ST_SCAN;
                            idx_next   = CW'(1);
                        end
                    end
                    pate_pkg::KIND_APPEND:
                    begin
                        if (full)
                        begin
                            res_status_next = pate_pkg::STAT_FULL;
                        end
                    end
                    pate_pkg::KIND_QUERY:
                    begin
                        if (empty)
                        begin
                            res_status_next = pate_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            state_next = pate_pkg::ST_LAST;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pate_pkg::ST_LAST:
            begin
                if (stat.ge_last)
                begin
                    res_kind_next = pate_pkg::RES_FINAL;
                    state_next    = pate_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pate_pkg::ST_SCAN;
                    idx_next   = CW'(1);
                end
            end
            pate_pkg::ST_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = (stat.kind == pate_pkg::KIND_QUERY) ?
                                 pate_pkg::ST_ATP : pate_pkg::ST_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = pate_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pate_pkg::ST_ATP: state_next = pate_pkg::ST_VTP;
            pate_pkg::ST_VTP: state_next = pate_pkg::ST_TT;
            pate_pkg::ST_TT:  state_next = pate_pkg::ST_ALO;
            pate_pkg::ST_ALO: state_next = pate_pkg::ST_AHI;
            pate_pkg::ST_AHI: state_next = pate_pkg::ST_ACC;
            pate_pkg::ST_ACC:
            begin
                res_kind_next = pate_pkg::RES_EVAL;
                state_next    = pate_pkg::ST_FINISH;
            end
            pate_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = pate_pkg::ST_IDLE;
                end
            end
            default: state_next = pate_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_step   = pate_pkg::MS_NONE;
        cmd.res_kind   = res_kind_reg;
        cmd.res_status = res_status_reg;
        rd_addr        = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            pate_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pate_pkg::ST_DECODE:
            begin
                unique case (stat.kind)
                    pate_pkg::KIND_TRUNC:
                    begin
                        cmd.set_offset = 1'b1;
                        cmd.rd_en      = !empty;
                        cmd.clear_prev = 1'b1;
                    end
                    pate_pkg::KIND_APPEND:
                    begin
                        cmd.append_wr = !full;
                    end
                    pate_pkg::KIND_QUERY:
                    begin
                        cmd.rd_en = !empty;
                        rd_addr   = last_idx[AW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            pate_pkg::ST_LAST:
            begin
                cmd.rd_en      = !stat.ge_last;
                cmd.clear_prev = 1'b1;
            end
            pate_pkg::ST_SCAN:
            begin
                cmd.track = 1'b1;
                rd_addr   = idx_reg[AW-1:0];
                if (stat.hit)
                begin
                    cmd.trunc_wr = stat.kind != pate_pkg::KIND_QUERY;
                    cmd.capture  = stat.kind == pate_pkg::KIND_QUERY;
                end
                else
                begin
                    cmd.rd_en = !scan_last;
                end
            end
            pate_pkg::ST_ATP: cmd.mul_step = pate_pkg::MS_ATP;
            pate_pkg::ST_VTP: cmd.mul_step = pate_pkg::MS_VTP;
            pate_pkg::ST_TT:  cmd.mul_step = pate_pkg::MS_TT;
            pate_pkg::ST_ALO: cmd.mul_step = pate_pkg::MS_ALO;
            pate_pkg::ST_AHI: cmd.mul_step = pate_pkg::MS_AHI;
            pate_pkg::ST_ACC: cmd.mul_step = pate_pkg::MS_ACC;
            pate_pkg::ST_FINISH:
            begin
                cmd.res_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pate_pkg::ST_SCAN) |-> stat.rd_valid)
        else $error("scan compare without table read data");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == pate_pkg::ST_IDLE) && !cmd.res_load)
        else $error("input taken while an item is in flight");
    a_eval_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pate_pkg::ST_ACC) |=> (state_reg == pate_pkg::ST_FINISH)
        && (res_kind_reg == pate_pkg::RES_EVAL))
        else $error("evaluation did not reach the result stage");
`endif

endmodule

@@ hdl/piecewise_accel_trajectory_eval_top.sv @@
// ----------------------------------------------------------------------------
// piecewise_accel_trajectory_eval_top: trajectory evaluator top level
// Append and unused kinds need no table read before the result; truncate
// scans the end-time table up to the segment where the scan stops.
// Query: an empty table or a time past the end needs no scan; otherwise
// the end-time scan (one table read per cycle) and five multiplier passes.
// Throughput: one item at a time; the next is taken once its result is held.
// Reset clears segment count, offset, final position and control; table
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module piecewise_accel_trajectory_eval_top #(
    parameter int MAX_SEGMENTS = pate_pkg::DEF_MAX_SEGMENTS
) (
    input  logic          clk,
    input  logic          rst_n,
    pate_item_if.sink     item,
    pate_result_if.source result,
    pate_cfg_if.sink      cfg
);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    pate_pkg::pate_cmd_t  cmd;
    pate_pkg::pate_stat_t stat;
    logic [CW-1:0]        count;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        rd_addr_q;
    logic                 in_ready;

    assign item.ready = in_ready;

    pate_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .stat      (stat),
        .count     (count),
        .rd_addr_q (rd_addr_q),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    pate_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .stat          (stat),
        .count         (count),
        .rd_addr_q     (rd_addr_q),
        .kind          (item.kind),
        .time_value    (item.time_value),
        .seg_end_rel   (item.seg_end_rel),
        .seg_accel     (item.seg_accel),
        .seg_start_vel (item.seg_start_vel),
        .seg_start_pos (item.seg_start_pos),
        .result        (result),
        .cfg           (cfg)
    );

endmodule

@@ test/trajectory_checker.sv @@
// ----------------------------------------------------------------------------
// trajectory_checker: result predictor and comparator
// Watches the item, result and configuration channels, models the segment
// table, computes the expected result of every accepted item and compares
// each result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module trajectory_checker (
    input  logic   clk,
    input  logic   rst_n,
    pate_item_if   item,
    pate_result_if result,
    pate_cfg_if    cfg,
    output int     fail_count,
    output int     pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] accel;
        logic [31:0] velocity;
        logic [31:0] position;
    } traj_result_t;

    localparam int NSEG = pate_pkg::DEF_MAX_SEGMENTS;

    logic signed [31:0] end_tab [NSEG];
    logic signed [31:0] acc_tab [NSEG];
    logic signed [31:0] vel_tab [NSEG];
    logic signed [31:0] pos_tab [NSEG];
    int                 num_segs;
    logic signed [31:0] offset_time;
    logic signed [31:0] final_pos;
    traj_result_t       expected_q [$];

    // Floor-shift a wide value and clamp it to the signed 32-bit range.
    function automatic logic [31:0] clamp_shift(logic signed [127:0] w, int k);
        logic signed [127:0] s;
        s = w >>> k;
        if (s > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -128'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic traj_result_t evaluate_item(logic [1:0] kind,
            logic signed [31:0] tv, logic [30:0] rel, logic signed [31:0] a_in,
            logic signed [31:0] v_in, logic signed [31:0] p_in);
        traj_result_t r;
        logic signed [63:0] e, q, start, tp;
        logic signed [127:0] w, a, v, p, t;
        int i;
        r = '0;
        r.status = pate_pkg::STAT_OK;
        if (kind == pate_pkg::KIND_TRUNC) begin
            for (i = 0; i < num_segs; i++)
            begin
                if (tv <= end_tab[i])
                begin
                    end_tab[i] = tv;
                    num_segs = i + 1;
                    break;
                end
            end
            offset_time = tv;
        end else if (kind == pate_pkg::KIND_APPEND) begin
            if (num_segs >= NSEG)
                r.status = pate_pkg::STAT_FULL;
            else
            begin
                e = 64'(offset_time) + 64'($signed({1'b0, rel}));
                if (e > 64'sd2147483647) e = 64'sd2147483647;
                end_tab[num_segs] = e[31:0];
                acc_tab[num_segs] = a_in;
                vel_tab[num_segs] = v_in;
                pos_tab[num_segs] = p_in;
                num_segs++;
            end
        end else if (kind == pate_pkg::KIND_QUERY) begin
            if (num_segs == 0)
                r.status = pate_pkg::STAT_EMPTY;
            else
            begin
                q = (tv < 0) ? 64'sd0 : 64'(tv);
                if (q >= 64'(end_tab[num_segs - 1]))
                    r.position = final_pos;
                else
                begin
                    start = 0;
                    for (i = 0; i < num_segs; i++)
                    begin
                        if (q <= 64'(end_tab[i])) break;
                        start = 64'(end_tab[i]);
                    end
                    tp = q - start;
                    a = 128'(acc_tab[i]);
                    v = 128'(vel_tab[i]);
                    p = 128'(pos_tab[i]);
                    t = 128'(tp);
                    r.accel = acc_tab[i];
                    w = (v <<< 16) + a * t;
                    r.velocity = clamp_shift(w, 16);
                    w = (p <<< 33) + ((v * t) <<< 17) + a * t * t;
                    r.position = clamp_shift(w, 33);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        traj_result_t got, exp_r;
        if (!rst_n)
        begin
            num_segs <= 0;
            offset_time <= 0;
            final_pos <= 0;
            fail_count <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                final_pos = cfg.data;
            if (item.valid && item.ready)
                expected_q.insert(expected_q.size(), evaluate_item(item.kind,
                    item.time_value, item.seg_end_rel, item.seg_accel,
                    item.seg_start_vel, item.seg_start_pos));
            if (result.valid && result.ready)
            begin
                got = {result.status, result.accel_out, result.velocity_out,
                       result.position_out};
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: st %0d/%0d acc %h/%h vel %h/%h pos %h/%h",
                                exp_r.status, got.status, exp_r.accel, got.accel,
                                exp_r.velocity, got.velocity, exp_r.position,
                                got.position);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: trajectory evaluator test
// Writes the final-position register across several settings, sends directed
// and random segment tables, truncations and queries with random gaps and
// back-pressure, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   long_hold;

    pate_item_if   item();
    pate_result_if result();
    pate_cfg_if    cfg();

    piecewise_accel_trajectory_eval_top dut (
        .clk(clk), .rst_n(rst_n), .item(item), .result(result), .cfg(cfg)
    );

    trajectory_checker u_checker (
        .clk(clk), .rst_n(rst_n), .item(item), .result(result), .cfg(cfg),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0004_0000);
            3: return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // Valid stays high across a zero gap so items can go back to back.
    task automatic send_item(logic [1:0] kind, logic [31:0] tv, logic [30:0] rel,
                             logic [31:0] a, logic [31:0] v, logic [31:0] p);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.kind <= kind;
        item.time_value <= tv;
        item.seg_end_rel <= rel;
        item.seg_accel <= a;
        item.seg_start_vel <= v;
        item.seg_start_pos <= p;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic write_final(logic [31:0] value);
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        logic [31:0] tv;
        r = $urandom_range(0, 99);
        tv = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 32'h0008_0000);
        if (r < 8)
            send_item(pate_pkg::KIND_TRUNC, tv, 31'($urandom()), rand_word(), rand_word(),
                      rand_word());
        else if (r < 40)
            send_item(pate_pkg::KIND_APPEND, $urandom(),
                      31'(($urandom_range(0, 7) == 0) ? $urandom()
                                                      : $urandom_range(0, 32'h3_0000)),
                      rand_word(), rand_word(), rand_word());
        else if (r < 97)
            send_item(pate_pkg::KIND_QUERY, tv, 31'($urandom()), $urandom(), $urandom(),
                      $urandom());
        else
            send_item(pate_pkg::KIND_UNUSED, $urandom(), 31'($urandom()), $urandom(),
                      $urandom(), $urandom());
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                result.ready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold = 0;
            end
            g = gap_len();
            result.ready <= (g == 0);
            repeat (g == 0 ? $urandom_range(1, 20) : g) @(posedge clk);
        end
    end

    initial
    begin
        item.valid = 0;
        item.kind = pate_pkg::KIND_TRUNC;
        item.time_value = 0;
        item.seg_end_rel = 0;
        item.seg_accel = 0;
        item.seg_start_vel = 0;
        item.seg_start_pos = 0;
        cfg.valid = 0;
        cfg.data = 0;
        long_hold = 0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty query, extremes, full table, past-end, unused kind.
        send_item(pate_pkg::KIND_QUERY, 32'h0001_0000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_APPEND, '0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_item(pate_pkg::KIND_QUERY, 32'h8000_0000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_QUERY, 32'h7FFF_FFFF, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_QUERY, 32'h4000_0000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_TRUNC, 32'h0001_0000, '0, '0, '0, '0);
        for (int i = 0; i < pate_pkg::DEF_MAX_SEGMENTS; i++)
            send_item(pate_pkg::KIND_APPEND, '0, 31'((i + 1) << 16), 32'h8000_0000 + i,
                      32'h8000_0000, 32'h8000_0000);
        send_item(pate_pkg::KIND_QUERY, 32'h0003_8000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_QUERY, 32'h0020_0000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1, '1, '1);
        write_final(32'h7FFF_FFFF);
        send_item(pate_pkg::KIND_QUERY, 32'h0020_0000, '0, '0, '0, '0);
        send_item(pate_pkg::KIND_TRUNC, 32'h8000_0000, '0, '0, '0, '0);

        long_hold = 1;
        for (int n = 0; n < 500; n++)
        begin
            if (n % 125 == 124)
                write_final((n == 249) ? 32'h8000_0000 : $urandom());
            random_item();
        end

        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("piecewise_accel_trajectory_eval_top verification clean");
        else
            $display("piecewise_accel_trajectory_eval_top verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("piecewise_accel_trajectory_eval_top verification failed");
        $finish;
    end
endmodule
